@@ rtl/fppa_pkg.sv @@
// ----------------------------------------------------------------------------
// fppa_pkg: shared constants and types for the partition allocator
// Sizes, register indexes, policy codes and the control/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package fppa_pkg;

   localparam int NUM_PARTITIONS = 16;
   localparam int SIZE_BITS      = 16;

   // Port widths fixed by the word format
   localparam int SLOT_W  = 4;
   localparam int SIZE_W  = 16;
   localparam int CSR_W   = 5;
   localparam int CSR_IDX_W = 1;

   // Table index and search-count widths
   localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_IN_USE = 1'b1;

   // Policy codes (the unused code behaves as first fit)
   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   localparam logic [4:0] BLOCKS_RESET = 5'd16;

   typedef struct packed {
      logic load_wr;      // write a partition's free size
      logic alloc_start;  // latch request, clear the scan
      logic scan_step;    // evaluate one partition
      logic finish;       // write back and emit the result
   } fppa_cmd_type;

   typedef struct packed {
      logic limit_zero;   // configured search count is zero
      logic scan_last;    // current partition is the last one searched
   } fppa_status_type;

endpackage

@@ rtl/fppa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fppa_ctrl: sequencer for the partition allocator
// Accepts request words and steps the datapath through the table scan.
// ----------------------------------------------------------------------------
module fppa_ctrl
   import fppa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_type,
   input  fppa_status_type status,
   output logic            busy,
   output fppa_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in        = state_ff;
      cmd.load_wr     = 1'b0;
      cmd.alloc_start = 1'b0;
      cmd.scan_step   = 1'b0;
      cmd.finish      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.alloc_start = 1'b1;
                  state_in = status.limit_zero ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Allocate with a nonzero search count always enters the scan
   a_alloc_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_ALLOC && !status.limit_zero) |=> state_ff == ST_SCAN)
      else $error("allocate did not enter scan");

   // Write-back is always followed by idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == ST_IDLE)
      else $error("controller not idle after finish");

   // A load never occupies the controller
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_wr |=> !busy)
      else $error("load left the controller busy");

endmodule

@@ rtl/fppa_dpath.sv @@
// ----------------------------------------------------------------------------
// fppa_dpath: free-size table, fit search and result registers
// Holds the configuration, scans one partition per step, writes back.
// ----------------------------------------------------------------------------
module fppa_dpath
   import fppa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [SLOT_W-1:0]    req_slot_index,
   input  logic [SIZE_W-1:0]    req_size_value,
   input  fppa_cmd_type         cmd,
   output fppa_status_type      status,
   output logic                 rsp_valid,
   output logic                 rsp_found,
   output logic [SLOT_W-1:0]    rsp_chosen_slot,
   output logic [SIZE_W-1:0]    rsp_free_before,
   output logic [SIZE_W-1:0]    rsp_free_after
);

   logic [1:0]           policy_ff, policy_in;
   logic [4:0]           blocks_ff, blocks_in;
   logic [1:0]           pol_ff, pol_in;        // policy latched per request
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 have_ff, have_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic [SIZE_BITS-1:0] table_ff [NUM_PARTITIONS];
   logic [SIZE_BITS-1:0] table_in [NUM_PARTITIONS];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [SIZE_W-1:0]    rsp_before_ff, rsp_before_in;
   logic [SIZE_W-1:0]    rsp_after_ff, rsp_after_in;

   logic [SIZE_BITS-1:0] cur_val;
   logic [SIZE_BITS-1:0] remain;
   logic                 take;
   logic [CNT_W-1:0]     cfg_limit;

   // search count clamped to the table depth
   assign cfg_limit = (32'(blocks_ff) > NUM_PARTITIONS) ? CNT_W'(NUM_PARTITIONS)
                                                         : CNT_W'(blocks_ff);

   assign status.limit_zero = (blocks_ff == 5'd0);
   assign status.scan_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == limit_ff);

   assign cur_val = table_ff[idx_ff];
   assign remain  = best_ff - size_ff;

   // first fit (and the spare code) only takes the first candidate
   assign take = (cur_val >= size_ff) &&
                 (!have_ff ||
                  (pol_ff == POLICY_BEST  && cur_val < best_ff) ||
                  (pol_ff == POLICY_WORST && cur_val > best_ff));

   always_comb begin
      policy_in     = policy_ff;
      blocks_in     = blocks_ff;
      pol_in        = pol_ff;
      limit_in      = limit_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      have_in       = have_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      table_in      = table_ff;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_before_in = rsp_before_ff;
      rsp_after_in  = rsp_after_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_FIT_POLICY:    policy_in = csr_wdata[1:0];
            CSR_BLOCKS_IN_USE: blocks_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      if (cmd.load_wr && (32'(req_slot_index) < NUM_PARTITIONS)) begin
         table_in[IDX_W'(req_slot_index)] = SIZE_BITS'(req_size_value);
      end

      if (cmd.alloc_start) begin
         pol_in   = policy_ff;
         limit_in = cfg_limit;
         size_in  = SIZE_BITS'(req_size_value);
         idx_in   = '0;
         have_in  = 1'b0;
         pick_in  = '0;
         best_in  = '0;
      end

      if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (take) begin
            have_in = 1'b1;
            pick_in = idx_ff;
            best_in = cur_val;
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = have_ff;
         if (have_ff) begin
            table_in[pick_ff] = remain;
            rsp_slot_in   = SLOT_W'(pick_ff);
            rsp_before_in = SIZE_W'(best_ff);
            rsp_after_in  = SIZE_W'(remain);
         end else begin
            rsp_slot_in   = '0;
            rsp_before_in = '0;
            rsp_after_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_FIRST;
         blocks_ff    <= BLOCKS_RESET;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         for (int i = 0; i < NUM_PARTITIONS; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         policy_ff    <= policy_in;
         blocks_ff    <= blocks_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
         table_ff     <= table_in;
      end
   end

   always_ff @(posedge clock) begin
      pol_ff        <= pol_in;
      limit_ff      <= limit_in;
      size_ff       <= size_in;
      idx_ff        <= idx_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_before_ff <= rsp_before_in;
      rsp_after_ff  <= rsp_after_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_free_before = rsp_before_ff;
   assign rsp_free_after  = rsp_after_ff;

   // Result strobe only follows a write-back
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.finish))
      else $error("result strobe without finish");

   // A granted request never grows the free size
   a_after_le_before: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> rsp_after_ff <= rsp_before_ff)
      else $error("free size grew on allocate");

   // A miss reports all zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
         (rsp_slot_ff == '0 && rsp_before_ff == '0 && rsp_after_ff == '0))
      else $error("miss carries nonzero fields");

endmodule

@@ rtl/fit_policy_partition_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator: first/best/worst fit partition allocator
// Keeps a free-size table for fixed partitions and grants allocate requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on req_* when start is high and busy is low. A load
//   word (req_type 0) writes one partition's free size in the accept cycle,
//   gives no result and leaves busy low. An allocate word (req_type 1) scans
//   partitions 0 .. min(blocks_in_use,16)-1, one per cycle, through a
//   single compare unit, then writes the chosen partition back.
//   After the accept, the controller scans the searched partitions (the
//   clamped search count, 16 by default), then writes the result back and
//   registers it with rsp_valid. A new word can be accepted in the strobe
//   cycle; loads are taken at one per cycle while no allocate is busy.
//   The result side has no back-pressure: rsp_* are valid only in the
//   rsp_valid cycle and must be captured then.
//   Configuration (csr_we, csr_index, csr_wdata) must be written only while
//   idle, not enforced by the block: index 0 fit policy, index 1 blocks in use.
//   Reset (synchronous, active high) clears all free sizes to zero, sets
//   first fit and a search count of 16, and drops busy.
// ----------------------------------------------------------------------------
module fit_policy_partition_allocator
   import fppa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_type,
   input  logic [SLOT_W-1:0]    req_slot_index,
   input  logic [SIZE_W-1:0]    req_size_value,
   // result channel
   output logic                 rsp_valid,
   output logic                 rsp_found,
   output logic [SLOT_W-1:0]    rsp_chosen_slot,
   output logic [SIZE_W-1:0]    rsp_free_before,
   output logic [SIZE_W-1:0]    rsp_free_after,
   // configuration port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   fppa_cmd_type    cmd;
   fppa_status_type status;

   // sequencer: accept, scan steps, write-back
   fppa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // table, fit compare and result registers
   fppa_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_slot_index  (req_slot_index),
      .req_size_value  (req_size_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_chosen_slot (rsp_chosen_slot),
      .rsp_free_before (rsp_free_before),
      .rsp_free_after  (rsp_free_after)
   );

endmodule
